>>> hdl/rtfx_pkg.sv
// Shared types, constants and helper functions for the radiotap field extractor.
package rtfx_pkg;

	// Number of present bits walked, and the index that marks the walk as finished.
	localparam int unsigned FIELD_COUNT = 7;
	localparam logic [2:0] FIELD_NONE = 3'd7;

	// Field indexes that need special handling during the walk.
	localparam logic [2:0] FIELD_TSFT    = 3'd0;
	localparam logic [2:0] FIELD_CHANNEL = 3'd3;
	localparam logic [2:0] FIELD_FHSS    = 3'd4;
	localparam logic [2:0] FIELD_SIGNAL  = 3'd5;
	localparam logic [2:0] FIELD_NOISE   = 3'd6;

	// Bit positions inside the captured flags.
	localparam int unsigned CAP_SIGNAL  = 0;
	localparam int unsigned CAP_CHANNEL = 1;
	localparam int unsigned CAP_NOISE   = 2;

	// Fixed header layout.
	localparam logic [15:0] POS_MAX        = 16'hFFFF;
	localparam logic [15:0] HEADER_BYTES   = 16'd8;
	localparam logic [2:0]  POS_LEN_LO     = 3'd2;
	localparam logic [2:0]  POS_LEN_HI     = 3'd3;
	localparam logic [2:0]  POS_PRESENT_LO = 3'd4;
	localparam logic [2:0]  POS_PRESENT_HI = 3'd7;

	// Parser state carried from one byte to the next.
	typedef struct packed {
		logic [15:0] byte_position;
		logic [15:0] length_word;
		logic [6:0]  present_bits;
		logic        extension_pending;
		logic [2:0]  field_index;
		logic [15:0] next_field_start;
		logic [7:0]  signal_value;
		logic [15:0] freq_value;
		logic [7:0]  noise_value;
		logic [2:0]  captured_flags;
		logic        fields_done;
	} rtfx_state_t;

	// Lowest present field at or above the given index, or FIELD_NONE if there is none.
	function automatic logic [2:0] next_present(input logic [6:0] bits, input logic [3:0] from);
		logic [2:0] idx;
		logic       found;
		idx = FIELD_NONE;
		found = 1'b0;
		for (int i = 0; i < FIELD_COUNT; i++) begin
			if (!found && bits[i] && (4'(i) >= from)) begin
				idx = 3'(i);
				found = 1'b1;
			end
		end
		return idx;
	endfunction

	// Start of a field once the walk position is rounded up to its alignment.
	function automatic logic [16:0] field_start(input logic [15:0] pos, input logic [2:0] idx);
		logic [16:0] wide;
		wide = {1'b0, pos};
		case (idx)
			FIELD_TSFT:                return (wide + 17'd7) & ~17'd7;
			FIELD_CHANNEL, FIELD_FHSS: return (wide + 17'd1) & ~17'd1;
			default:                   return wide;
		endcase
	endfunction

	// Size of a field in bytes, minus one.
	function automatic logic [2:0] field_last(input logic [2:0] idx);
		case (idx)
			FIELD_TSFT:    return 3'd7;
			FIELD_CHANNEL: return 3'd3;
			FIELD_FHSS:    return 3'd1;
			default:       return 3'd0;
		endcase
	endfunction

endpackage

>>> hdl/rtfx_step.sv
// Next-state logic of the parser for one packet byte.
module rtfx_step (
	input  rtfx_pkg::rtfx_state_t cur,
	input  logic [7:0]            data_byte,
	output rtfx_pkg::rtfx_state_t nxt
);

	logic [15:0] pos;
	logic [16:0] start;
	logic [16:0] rel;
	logic [2:0]  first_idx;
	logic [2:0]  follow_idx;

	assign pos = cur.byte_position;
	assign start = rtfx_pkg::field_start(cur.next_field_start, cur.field_index);
	assign rel = {1'b0, pos} - start;
	assign first_idx = rtfx_pkg::next_present(cur.present_bits, 4'd0);
	assign follow_idx = rtfx_pkg::next_present(cur.present_bits, {1'b0, cur.field_index} + 4'd1);

	// Header bytes, extension words and the field walk, one byte at a time.
	always_comb begin
		nxt = cur;
		if (pos != rtfx_pkg::POS_MAX) begin
			if (pos < rtfx_pkg::HEADER_BYTES) begin
				case (pos[2:0])
					rtfx_pkg::POS_LEN_LO: nxt.length_word[7:0] = data_byte;
					rtfx_pkg::POS_LEN_HI: nxt.length_word[15:8] = data_byte;
					rtfx_pkg::POS_PRESENT_LO: nxt.present_bits = data_byte[6:0];
					rtfx_pkg::POS_PRESENT_HI: begin
						if (data_byte[7]) begin
							nxt.extension_pending = 1'b1;
						end else begin
							nxt.field_index = first_idx;
							nxt.next_field_start = rtfx_pkg::HEADER_BYTES;
							nxt.fields_done = (first_idx == rtfx_pkg::FIELD_NONE);
						end
					end
					default: ;
				endcase
			end else if (cur.extension_pending) begin
				// The last byte of each extension word says whether another follows.
				if (pos[1:0] == 2'b11 && !data_byte[7]) begin
					nxt.extension_pending = 1'b0;
					nxt.field_index = first_idx;
					nxt.next_field_start = pos + 16'd1;
					nxt.fields_done = (first_idx == rtfx_pkg::FIELD_NONE);
				end
			end else if (!cur.fields_done && cur.field_index != rtfx_pkg::FIELD_NONE) begin
				if ({1'b0, pos} >= start) begin
					// Capture the bytes that are reported.
					if (rel == 17'd0) begin
						case (cur.field_index)
							rtfx_pkg::FIELD_SIGNAL: begin
								nxt.signal_value = data_byte;
								nxt.captured_flags[rtfx_pkg::CAP_SIGNAL] = 1'b1;
							end
							rtfx_pkg::FIELD_CHANNEL: nxt.freq_value[7:0] = data_byte;
							rtfx_pkg::FIELD_NOISE: begin
								nxt.noise_value = data_byte;
								nxt.captured_flags[rtfx_pkg::CAP_NOISE] = 1'b1;
							end
							default: ;
						endcase
					end else if (rel == 17'd1 && cur.field_index == rtfx_pkg::FIELD_CHANNEL) begin
						nxt.freq_value[15:8] = data_byte;
						nxt.captured_flags[rtfx_pkg::CAP_CHANNEL] = 1'b1;
					end
					// Move on to the next present field after the last byte of this one.
					if (rel >= {14'd0, rtfx_pkg::field_last(cur.field_index)}) begin
						nxt.next_field_start = pos + 16'd1;
						nxt.field_index = follow_idx;
						nxt.fields_done = (follow_idx == rtfx_pkg::FIELD_NONE);
					end
				end
			end
			nxt.byte_position = pos + 16'd1;
		end
	end

endmodule

>>> hdl/radiotap_field_extractor.sv
// Top level of the radiotap field extractor: parser state, handshakes and result register.
//
// The block takes one packet byte per cycle, header first, and parses the radiotap
// header on the fly: length, present word, skipped extension present words and the
// fields of present bits 0 to 6, capturing antenna signal, channel frequency and
// noise. Each byte is handled in the cycle it is accepted; the parser state
// registers update at that edge, and the byte marked last loads the result register
// and clears the parser for the next packet, so bytes of the next packet may follow
// in the very next cycle. Throughput is one byte per cycle. The input stalls only
// while a packet's result is still held in the result register and not taken.
module radiotap_field_extractor (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         data_byte,
	input  logic               last_byte,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [15:0]        header_length,
	output logic signed [7:0]  signal_dbm,
	output logic [15:0]        freq_mhz,
	output logic signed [7:0]  noise_level,
	output logic               signal_present,
	output logic               channel_present,
	output logic               noise_present,
	output logic               header_ok,
	output logic               usable
);

	rtfx_pkg::rtfx_state_t state_q;
	rtfx_pkg::rtfx_state_t state_next;
	logic                  in_fire;
	logic                  sig;
	logic                  chan;
	logic                  noi;

	rtfx_step u_step (
		.cur       (state_q),
		.data_byte (data_byte),
		.nxt       (state_next)
	);

	// A new byte is taken unless a finished result is still waiting.
	assign in_ready = !out_valid || out_ready;
	assign in_fire = in_valid && in_ready;

	assign sig  = state_next.captured_flags[rtfx_pkg::CAP_SIGNAL];
	assign chan = state_next.captured_flags[rtfx_pkg::CAP_CHANNEL];
	assign noi  = state_next.captured_flags[rtfx_pkg::CAP_NOISE];

	// Parser state: advance on each byte, clear after the last byte of a packet.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (in_fire) begin
			if (last_byte) begin
				state_q <= '0;
			end else begin
				state_q <= state_next;
			end
		end
	end

	// Result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (in_fire && last_byte) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	// Result payload, loaded from the state after the last byte is applied.
	always_ff @(posedge clk) begin
		if (in_fire && last_byte) begin
			header_length   <= state_next.length_word;
			signal_dbm      <= sig ? state_next.signal_value : 8'sd0;
			freq_mhz        <= chan ? state_next.freq_value : 16'd0;
			noise_level     <= noi ? state_next.noise_value : 8'sd0;
			signal_present  <= sig;
			channel_present <= chan;
			noise_present   <= noi;
			header_ok       <= state_next.fields_done;
			usable          <= state_next.fields_done && sig && (state_next.signal_value != 8'd0);
		end
	end

endmodule

>>> tb/tb_radiotap_field_extractor.sv
// Self-checking testbench for the radiotap field extractor, with its own parser prediction.
module tb_radiotap_field_extractor;

	// One byte waiting to be sent; drain holds it back until every pending report has arrived.
	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       drain;
	} rt_byte_t;

	// One report as the block should present it.
	typedef struct packed {
		logic [15:0] hdr_len;
		logic [7:0]  signal;
		logic [15:0] freq;
		logic [7:0]  noise;
		logic        sig_seen;
		logic        chan_seen;
		logic        noise_seen;
		logic        hdr_ok;
		logic        usable;
	} rt_report_t;

	// Parser state as the testbench tracks it.
	typedef struct packed {
		logic [15:0] pos;
		logic [15:0] hdr_len;
		logic [6:0]  present;
		logic        in_ext;
		logic [2:0]  fidx;
		logic [15:0] walk_from;
		logic [7:0]  sig;
		logic [15:0] freq;
		logic [7:0]  noise;
		logic [2:0]  got;
		logic        walk_done;
	} rt_parse_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  data_byte = 8'h00;
	logic        last_byte = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [15:0] header_length;
	logic [7:0]  signal_dbm;
	logic [15:0] freq_mhz;
	logic [7:0]  noise_level;
	logic        signal_present;
	logic        channel_present;
	logic        noise_present;
	logic        header_ok;
	logic        usable;

	rt_byte_t    pending_bytes[$];
	rt_report_t  expected_reports[$];
	rt_parse_t   parse_st = '0;
	rt_report_t  want;
	logic [7:0]  pkt_buf [0:63];
	int          pkt_len;
	int          bytes_accepted = 0;
	int          reports_seen = 0;
	int          error_count = 0;
	int          hold_left = 0;
	logic        hold_started = 1'b0;

	radiotap_field_extractor u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.data_byte(data_byte),
		.last_byte(last_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.header_length(header_length),
		.signal_dbm(signal_dbm),
		.freq_mhz(freq_mhz),
		.noise_level(noise_level),
		.signal_present(signal_present),
		.channel_present(channel_present),
		.noise_present(noise_present),
		.header_ok(header_ok),
		.usable(usable)
	);

	// Free-running clock.
	initial begin
		forever #10 clk = ~clk;
	end

	// Alignment of each radiotap field, counted from the header start.
	function automatic int unsigned field_alignment(input logic [2:0] idx);
		case (idx)
			rtfx_pkg::FIELD_TSFT:                          return 8;
			rtfx_pkg::FIELD_CHANNEL, rtfx_pkg::FIELD_FHSS: return 2;
			default:                                       return 1;
		endcase
	endfunction

	// Size of each radiotap field in bytes.
	function automatic int unsigned field_bytes(input logic [2:0] idx);
		case (idx)
			rtfx_pkg::FIELD_TSFT:    return 8;
			rtfx_pkg::FIELD_CHANNEL: return 4;
			rtfx_pkg::FIELD_FHSS:    return 2;
			default:                 return 1;
		endcase
	endfunction

	// Random idle decision; nobody idles while the byte count sits in the quiet window.
	function automatic bit coin_idle();
		if (bytes_accepted >= 800 && bytes_accepted < 1100)
			return 1'b0;
		return $urandom_range(99) < 27;
	endfunction

	// Move the walk to the next present field, or mark the walk finished.
	task automatic skip_absent();
		while (parse_st.fidx != rtfx_pkg::FIELD_NONE && !parse_st.present[parse_st.fidx])
			parse_st.fidx = parse_st.fidx + 3'd1;
		if (parse_st.fidx == rtfx_pkg::FIELD_NONE)
			parse_st.walk_done = 1'b1;
	endtask

	// Start walking the fields at the given byte position.
	task automatic start_walk(input logic [15:0] from);
		parse_st.fidx = 3'd0;
		parse_st.walk_from = from;
		skip_absent();
	endtask

	// Advance the predicted parser by one byte and queue a report on the last byte.
	task automatic predict_byte(input logic [7:0] b, input logic is_last);
		int unsigned p;
		int unsigned al;
		int unsigned start;
		int unsigned rel;
		rt_report_t  rep;
		p = parse_st.pos;
		if (p < rtfx_pkg::POS_MAX) begin
			if (p < rtfx_pkg::HEADER_BYTES) begin
				if (p == rtfx_pkg::POS_LEN_LO)
					parse_st.hdr_len[7:0] = b;
				else if (p == rtfx_pkg::POS_LEN_HI)
					parse_st.hdr_len[15:8] = b;
				else if (p == rtfx_pkg::POS_PRESENT_LO)
					parse_st.present = b[6:0];
				else if (p == rtfx_pkg::POS_PRESENT_HI) begin
					if (b[7])
						parse_st.in_ext = 1'b1;
					else
						start_walk(rtfx_pkg::HEADER_BYTES);
				end
			end else if (parse_st.in_ext) begin
				// The last byte of each extension word says whether another follows.
				if ((p - 8) % 4 == 3 && !b[7]) begin
					parse_st.in_ext = 1'b0;
					start_walk(16'(p + 1));
				end
			end else if (!parse_st.walk_done && parse_st.fidx != rtfx_pkg::FIELD_NONE) begin
				al = field_alignment(parse_st.fidx);
				start = parse_st.walk_from;
				start = (start + al - 1) / al * al;
				if (p >= start) begin
					rel = p - start;
					if (parse_st.fidx == rtfx_pkg::FIELD_SIGNAL && rel == 0) begin
						parse_st.sig = b;
						parse_st.got[rtfx_pkg::CAP_SIGNAL] = 1'b1;
					end else if (parse_st.fidx == rtfx_pkg::FIELD_CHANNEL && rel == 0) begin
						parse_st.freq[7:0] = b;
					end else if (parse_st.fidx == rtfx_pkg::FIELD_CHANNEL && rel == 1) begin
						parse_st.freq[15:8] = b;
						parse_st.got[rtfx_pkg::CAP_CHANNEL] = 1'b1;
					end else if (parse_st.fidx == rtfx_pkg::FIELD_NOISE && rel == 0) begin
						parse_st.noise = b;
						parse_st.got[rtfx_pkg::CAP_NOISE] = 1'b1;
					end
					if (rel + 1 >= field_bytes(parse_st.fidx)) begin
						parse_st.walk_from = 16'(p + 1);
						parse_st.fidx = parse_st.fidx + 3'd1;
						skip_absent();
					end
				end
			end
			parse_st.pos = 16'(p + 1);
		end
		if (is_last) begin
			rep.hdr_len = parse_st.hdr_len;
			rep.signal = parse_st.got[rtfx_pkg::CAP_SIGNAL] ? parse_st.sig : 8'h00;
			rep.freq = parse_st.got[rtfx_pkg::CAP_CHANNEL] ? parse_st.freq : 16'h0000;
			rep.noise = parse_st.got[rtfx_pkg::CAP_NOISE] ? parse_st.noise : 8'h00;
			rep.sig_seen = parse_st.got[rtfx_pkg::CAP_SIGNAL];
			rep.chan_seen = parse_st.got[rtfx_pkg::CAP_CHANNEL];
			rep.noise_seen = parse_st.got[rtfx_pkg::CAP_NOISE];
			rep.hdr_ok = parse_st.walk_done;
			rep.usable = parse_st.walk_done && parse_st.got[rtfx_pkg::CAP_SIGNAL] &&
				parse_st.sig != 8'h00;
			expected_reports.push_back(rep);
			parse_st = '0;
		end
	endtask

	// Compare one report field and log a mismatch.
	task automatic check_field(input string what, input logic [15:0] exp_v,
			input logic [15:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, exp_v, act_v);
			error_count++;
		end
	endtask

	// Queue the packet held in pkt_buf.
	task automatic push_packet(input logic drain);
		rt_byte_t item;
		for (int i = 0; i < pkt_len; i++) begin
			item.data = pkt_buf[i];
			item.last = (i == pkt_len - 1);
			item.drain = drain && (i == 0);
			pending_bytes.push_back(item);
		end
	endtask

	// Load a directed packet written as a hex string, first byte leftmost.
	task automatic load_vector(input logic [255:0] v, input int n);
		pkt_len = n;
		for (int i = 0; i < n; i++)
			pkt_buf[i] = v[8 * (n - 1 - i) +: 8];
	endtask

	// Build a random packet: mostly well-formed headers, some truncated, some pure noise.
	task automatic build_random_packet();
		int unsigned n_ext;
		int unsigned pos;
		int unsigned al;
		int unsigned sig_at;
		int unsigned pick;
		logic [6:0]  bits;
		logic        has_sig;
		if ($urandom_range(99) < 12) begin
			pkt_len = $urandom_range(1, 24);
			for (int i = 0; i < pkt_len; i++)
				pkt_buf[i] = 8'($urandom);
		end else begin
			pick = $urandom_range(9);
			bits = (pick == 0) ? 7'h00 : (pick == 1) ? 7'h7F : 7'($urandom);
			n_ext = ($urandom_range(3) == 0) ? $urandom_range(1, 3) : 0;
			pos = 8 + 4 * n_ext;
			has_sig = 1'b0;
			sig_at = 0;
			for (int f = 0; f < rtfx_pkg::FIELD_COUNT; f++) begin
				if (bits[f]) begin
					al = field_alignment(3'(f));
					pos = (pos + al - 1) / al * al;
					if (3'(f) == rtfx_pkg::FIELD_SIGNAL) begin
						sig_at = pos;
						has_sig = 1'b1;
					end
					pos += field_bytes(3'(f));
				end
			end
			pkt_len = pos + $urandom_range(0, 4);
			for (int i = 0; i < pkt_len; i++)
				pkt_buf[i] = 8'($urandom);
			pkt_buf[4] = {pkt_buf[4][7], bits};
			pkt_buf[7] = {n_ext != 0, pkt_buf[7][6:0]};
			for (int e = 0; e < n_ext; e++)
				pkt_buf[11 + 4 * e] = {e + 1 < n_ext, pkt_buf[11 + 4 * e][6:0]};
			// A zero signal must leave the packet unusable even with a good header.
			if (has_sig && $urandom_range(6) == 0)
				pkt_buf[sig_at] = 8'h00;
			if ($urandom_range(1) == 0) begin
				pkt_buf[2] = pos[7:0];
				pkt_buf[3] = pos[15:8];
			end
			if ($urandom_range(4) == 0)
				pkt_len = $urandom_range(1, pkt_len);
		end
	endtask

	// Driver: presents queued bytes and predicts each accepted transaction.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			data_byte <= 8'h00;
			last_byte <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				predict_byte(data_byte, last_byte);
				bytes_accepted <= bytes_accepted + 1;
			end
			if (!in_valid || in_ready) begin
				if (pending_bytes.size() != 0 && !coin_idle() &&
						!(pending_bytes[0].drain && expected_reports.size() != 0)) begin
					in_valid <= 1'b1;
					data_byte <= pending_bytes[0].data;
					last_byte <= pending_bytes[0].last;
					void'(pending_bytes.pop_front());
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: checks each report transaction and drives ready, with one long hold-off.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			hold_left <= 0;
		end else begin
			if (out_valid && out_ready) begin
				reports_seen <= reports_seen + 1;
				if (expected_reports.size() == 0) begin
					$display("%0t: unexpected report, expected none, actual length %0h signal %0h",
						$time, header_length, signal_dbm);
					error_count++;
				end else begin
					want = expected_reports.pop_front();
					check_field("header_length", want.hdr_len, header_length);
					check_field("signal_dbm", {8'h00, want.signal}, {8'h00, signal_dbm});
					check_field("freq_mhz", want.freq, freq_mhz);
					check_field("noise_level", {8'h00, want.noise}, {8'h00, noise_level});
					check_field("signal_present", {15'd0, want.sig_seen}, {15'd0, signal_present});
					check_field("channel_present", {15'd0, want.chan_seen}, {15'd0, channel_present});
					check_field("noise_present", {15'd0, want.noise_seen}, {15'd0, noise_present});
					check_field("header_ok", {15'd0, want.hdr_ok}, {15'd0, header_ok});
					check_field("usable", {15'd0, want.usable}, {15'd0, usable});
				end
			end
			if (!hold_started && bytes_accepted >= 400) begin
				hold_started <= 1'b1;
				hold_left <= 300;
				out_ready <= 1'b0;
			end else if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= !coin_idle();
			end
		end
	end

	// Stimulus, reset and end of run.
	initial begin
		int       random_goal;
		int       n_random;

		// Short packet: a single byte.
		load_vector(256'hFF, 1);
		push_packet(1'b0);
		// Header with no present fields; bit 7 of the first present byte is not a field.
		load_vector(256'h0000000080000000, 8);
		push_packet(1'b0);
		// One extension word, then channel at its extreme, signal at -128 and noise at 127.
		load_vector(256'h000012006800008035A5C300FFFF3C00807F, 18);
		push_packet(1'b0);

		// Random packets; the first of them, and the one that follows forty more, wait until the block has drained.
		random_goal = pending_bytes.size() + 1520;
		n_random = 0;
		while (pending_bytes.size() < random_goal) begin
			build_random_packet();
			push_packet(n_random == 0 || n_random == 40);
			n_random++;
		end

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_bytes.size() != 0 || in_valid)
			@(posedge clk);
		while (expected_reports.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("Sent %0d bytes and checked %0d reports: directed headers, random well-formed,",
			bytes_accepted, reports_seen);
		$display("truncated and noise packets, under random idling and a long output stall.");
		if (error_count == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

	// Watchdog.
	initial begin
		#20000000;
		$display("tb: failure");
		$finish;
	end

endmodule
